[src/fixed_block_free_list_allocator_defines.svh]
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on the rising clock outside reset.
`define FBFL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising clock outside reset.
`define FBFL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/fbfl_pkg.sv]
// Package for the free-list allocator: field widths, command codes and the
// sequencer state type. Depends on nothing.
package fbfl_pkg;

   localparam int INDEX_W = 8;
   localparam int LINK_W  = INDEX_W + 1;

   // Command codes carried on req_command.
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

[src/fbfl_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module fbfl_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/fixed_block_free_list_allocator.sv]
// Fixed-size pool allocator kept as a linked free list of entry indices.
// Depends on fbfl_pkg, fbfl_ram and fixed_block_free_list_allocator_defines.svh.
//
// Usage:
//   The req_ channel carries commands. req_command = allocate asks for an
//   entry; req_command = release returns req_entry_index to the pool. A
//   command is transferred when req_valid is high and req_stall is low.
//   Every allocate gives one transfer on the rsp_ channel with the granted
//   index and a warning bit that is set when the entry was the last free one
//   (that entry then stays on the list). A release gives no response, and a
//   release of an index outside the pool is dropped.
//   An allocate first reads the head's link from the link RAM, whose read
//   port is registered, before the head can move. The response is valid
//   the cycle after the read. A release writes one link word and moves the
//   head. A single output register holds the response; while it is full
//   and rsp_stall is high, new commands stall. Reset is synchronous. It
//   sets the head to entry 0 and clears one valid bit per link word; an
//   entry never written reads as linking to the next entry, the last one
//   as the list end. No clearing pass is needed, so the block takes
//   commands in the first cycle after reset.
module fixed_block_free_list_allocator
   import fbfl_pkg::*;
#(
   parameter int POOL_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [INDEX_W-1:0] req_entry_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [INDEX_W-1:0] rsp_granted_index,
   output logic               rsp_last_entry_warning
);

`include "fixed_block_free_list_allocator_defines.svh"

   localparam int LIVE_ENTRIES = (POOL_ENTRIES < (1 << INDEX_W)) ? POOL_ENTRIES : (1 << INDEX_W);
   localparam int AW = $clog2(LIVE_ENTRIES);
   localparam logic [LINK_W-1:0] LIVE_LIMIT = LINK_W'(LIVE_ENTRIES);
   localparam logic [LINK_W-1:0] LAST_ENTRY = LINK_W'(LIVE_ENTRIES - 1);

   state_type                 state_ff, state_in;
   logic [INDEX_W-1:0]        head_ff, head_in;
   logic [LIVE_ENTRIES-1:0]   valid_ff, valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic                      rsp_warn_ff, rsp_warn_in;

   logic                      req_xfer;
   logic                      rel_in_range;
   logic                      ram_wr_en;
   logic [LINK_W-1:0]         ram_rd_data;
   logic [LINK_W-1:0]         reset_link;
   logic [LINK_W-1:0]         head_link;

   assign req_stall    = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_xfer     = req_valid && !req_stall;
   assign rel_in_range = ({1'b0, req_entry_index} < LIVE_LIMIT);
   assign ram_wr_en    = req_xfer && (req_command == CMD_RELEASE) && rel_in_range;

   // Link word of an entry that has not been written since reset.
   assign reset_link = ({1'b0, head_ff} == LAST_ENTRY) ? {1'b1, {INDEX_W{1'b0}}}
                                                       : {1'b0, head_ff + INDEX_W'(1)};
   assign head_link  = valid_ff[head_ff[AW-1:0]] ? ram_rd_data : reset_link;

   // The RAM reads the head every cycle; in ST_READ the data belongs to the
   // head sampled at the allocate transfer, which has not moved since.
   fbfl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (LIVE_ENTRIES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_entry_index[AW-1:0]),
      .wr_data ({1'b0, head_ff}),
      .rd_addr (head_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_warn_in  = rsp_warn_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_command == CMD_ALLOC) begin
                  state_in = ST_READ;
               end else if (rel_in_range) begin
                  head_in = req_entry_index;
                  valid_in[req_entry_index[AW-1:0]] = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_index_in = head_ff;
            rsp_warn_in  = head_link[LINK_W-1];
            if (!head_link[LINK_W-1]) begin
               head_in = head_link[INDEX_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_warn_ff  <= rsp_warn_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_granted_index      = rsp_index_ff;
   assign rsp_last_entry_warning = rsp_warn_ff;

   `FBFL_ASSERT_SAME(a_read_slot_free, clock, reset, state_ff == ST_READ, !rsp_valid_ff,
      "allocate read finished while the response register was still full")
   `FBFL_ASSERT_SAME(a_head_in_pool, clock, reset, 1'b1, {1'b0, head_ff} < LIVE_LIMIT,
      "free-list head points outside the pool")
   `FBFL_ASSERT_NEXT(a_read_gives_rsp, clock, reset, state_ff == ST_READ, rsp_valid_ff,
      "allocate did not produce a response")
   `FBFL_ASSERT_NEXT(a_release_moves_head, clock, reset, ram_wr_en,
      head_ff == $past(req_entry_index), "release did not make the entry the new head")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the fixed-block free-list allocator.
// It drives allocate and release commands and checks each grant against a
// predictor of the link store and head. Depends on fbfl_pkg and the block.
`timescale 1ns / 1ps

module tb_top
   import fbfl_pkg::*;
();

   localparam int POOL_SIZE = 256;
   localparam int LIVE_SIZE = (POOL_SIZE < 256) ? POOL_SIZE : 256;
   localparam logic [LINK_W-1:0] LINK_END = 9'h100;
   localparam int RANDOM_COMMANDS = 480;
   localparam int LONG_HOLD_CYCLES = 60;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               warning;
   } grant_type;

   typedef struct {
      logic               cmd;
      logic [INDEX_W-1:0] idx;
      int                 count;
      bit                 typed;
      grant_type          want;
   } script_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_command = CMD_ALLOC;
   logic [INDEX_W-1:0] req_entry_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [INDEX_W-1:0] rsp_granted_index;
   logic               rsp_last_entry_warning;

   // Predictor state: one link word per entry (bit 8 marks the list end).
   logic [LINK_W-1:0]  link_word [LIVE_SIZE];
   logic [INDEX_W-1:0] head_index;

   grant_type          grants_due [$];
   logic [INDEX_W-1:0] held_entries [$];
   int                 mismatches = 0;
   bit                 calm = 1'b0;
   bit                 backlog_hold = 1'b0;

   // Directed sequence. The long allocate run walks the untouched chain down
   // to the last free entry, which is the only place where the end mark lives.
   script_row_type script [0:20] = '{
      '{CMD_ALLOC,   8'd0,   1,   1, '{8'd0,   1'b0}},
      '{CMD_ALLOC,   8'hFF,  1,   1, '{8'd1,   1'b0}},
      '{CMD_RELEASE, 8'd1,   1,   0, '{8'd0,   1'b0}},
      '{CMD_ALLOC,   8'd0,   1,   1, '{8'd1,   1'b0}},
      '{CMD_RELEASE, 8'd0,   1,   0, '{8'd0,   1'b0}},
      '{CMD_ALLOC,   8'h5A,  1,   1, '{8'd0,   1'b0}},
      '{CMD_ALLOC,   8'd0,   252, 0, '{8'd0,   1'b0}},
      '{CMD_ALLOC,   8'd0,   1,   1, '{8'd254, 1'b0}},
      '{CMD_ALLOC,   8'd0,   1,   1, '{8'd255, 1'b1}},
      '{CMD_ALLOC,   8'hFF,  1,   1, '{8'd255, 1'b1}},
      '{CMD_RELEASE, 8'd255, 1,   0, '{8'd0,   1'b0}},
      '{CMD_ALLOC,   8'd0,   1,   1, '{8'd255, 1'b0}},
      '{CMD_ALLOC,   8'd0,   1,   1, '{8'd255, 1'b0}},
      '{CMD_RELEASE, 8'd0,   1,   0, '{8'd0,   1'b0}},
      '{CMD_RELEASE, 8'd0,   1,   0, '{8'd0,   1'b0}},
      '{CMD_ALLOC,   8'd0,   1,   1, '{8'd0,   1'b0}},
      '{CMD_RELEASE, 8'hAA,  1,   0, '{8'd0,   1'b0}},
      '{CMD_RELEASE, 8'h55,  1,   0, '{8'd0,   1'b0}},
      '{CMD_ALLOC,   8'd0,   1,   1, '{8'h55,  1'b0}},
      '{CMD_ALLOC,   8'd0,   1,   1, '{8'hAA,  1'b0}},
      '{CMD_ALLOC,   8'd0,   1,   1, '{8'd0,   1'b0}}
   };

   fixed_block_free_list_allocator #(
      .POOL_ENTRIES(POOL_SIZE)
   ) dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_command            (req_command),
      .req_entry_index        (req_entry_index),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_granted_index      (rsp_granted_index),
      .rsp_last_entry_warning (rsp_last_entry_warning)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one command to the predicted pool and returns the grant, if any.
   function automatic bit pool_command(input logic cmd, input logic [INDEX_W-1:0] idx,
                                       output grant_type grant);
      logic [LINK_W-1:0] link;
      grant = '0;
      if (cmd == CMD_ALLOC) begin
         link = link_word[head_index];
         grant.index = head_index;
         if (link & LINK_END) begin
            grant.warning = 1'b1;
         end else begin
            grant.warning = 1'b0;
            head_index = link[INDEX_W-1:0];
         end
         return 1'b1;
      end
      if (int'(idx) < LIVE_SIZE) begin
         link_word[idx] = {1'b0, head_index};
         head_index = idx;
      end
      return 1'b0;
   endfunction

   // Offers one command, waits for its transfer and records the grant due.
   task automatic send(input logic cmd, input logic [INDEX_W-1:0] idx, input bit typed,
                       input grant_type want);
      grant_type predicted;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_entry_index <= idx;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (pool_command(cmd, idx, predicted)) begin
         grants_due.push_back(typed ? want : predicted);
         held_entries.push_back(predicted.index);
      end
   endtask

   initial begin : sender
      int i;
      int r;
      int k;
      int pick;
      logic [INDEX_W-1:0] idx;
      for (i = 0; i < LIVE_SIZE - 1; i++) begin
         link_word[i] = LINK_W'(i + 1);
      end
      link_word[LIVE_SIZE-1] = LINK_END;
      head_index = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < $size(script); r++) begin
         for (k = 0; k < script[r].count; k++) begin
            send(script[r].cmd, script[r].idx, script[r].typed, script[r].want);
         end
      end

      for (i = 0; i < RANDOM_COMMANDS; i++) begin
         calm = (i >= RANDOM_COMMANDS - 100) || ((i % 150) < 25);
         if (i == 200) begin
            backlog_hold = 1'b1;
         end
         if (i == 300) begin
            // Let the pipeline drain completely before going on.
            req_valid <= 1'b0;
            do @(posedge clock); while (grants_due.size() != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            // Unchecked release: any index, possibly free or the head itself.
            send(CMD_RELEASE, INDEX_W'($urandom_range(0, 255)), 1'b0, '0);
         end else if (pick < 55 && held_entries.size() > 0) begin
            k = $urandom_range(0, held_entries.size() - 1);
            idx = held_entries[k];
            held_entries.delete(k);
            send(CMD_RELEASE, idx, 1'b0, '0);
         end else begin
            send(CMD_ALLOC, INDEX_W'($urandom_range(0, 255)), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (grants_due.size() != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (backlog_hold) begin
            // Hold the output long enough for the block to back up its input.
            backlog_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      grant_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (grants_due.size() == 0) begin
            $display("%0t: grant with none due, actual index %0d warning %0b",
                     $time, rsp_granted_index, rsp_last_entry_warning);
            mismatches++;
         end else begin
            due = grants_due.pop_front();
            if (rsp_granted_index !== due.index) begin
               $display("%0t: granted_index mismatch, expected %0d, actual %0d",
                        $time, due.index, rsp_granted_index);
               mismatches++;
            end
            if (rsp_last_entry_warning !== due.warning) begin
               $display("%0t: last_entry_warning mismatch, expected %0b, actual %0b",
                        $time, due.warning, rsp_last_entry_warning);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/fbfl_pkg.sv
src/fbfl_ram.sv
src/fixed_block_free_list_allocator.sv
verif/tb_top.sv
